// ===== sv/ascd_pkg.sv =====
// Shared constants for the arctangent soft-clip distortion block:
// field widths, register indexes and reset values, and the CORDIC angle table.
// No dependencies.
package ascd_pkg;

    localparam int GAIN_W     = 16;   // drive, blend and volume registers
    localparam int RANGE_W    = 12;   // range pre-gain register
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int Z_W        = 22;   // shaped value, Q20 signed
    localparam int ANG_W      = 21;   // angle table entries, unsigned
    localparam int DIV_W      = 36;   // clean-path dividend / quotient bits
    localparam int TAB_LEN    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RANGE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BLEND  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = CFG_IDX_W'(3);

    localparam logic [GAIN_W-1:0]  DRIVE_RST  = 16'd32768;
    localparam logic [RANGE_W-1:0] RANGE_RST  = 12'd1;
    localparam logic [GAIN_W-1:0]  BLEND_RST  = 16'd32768;
    localparam logic [GAIN_W-1:0]  VOLUME_RST = 16'd16384;

    // atan(2^-i) * (2/pi), Q20
    function automatic logic [ANG_W-1:0] ang_of(input int idx);
        logic [ANG_W-1:0] a;
        case (idx)
            0:  a = 21'd524288;
            1:  a = 21'd309505;
            2:  a = 21'd163534;
            3:  a = 21'd83012;
            4:  a = 21'd41667;
            5:  a = 21'd20854;
            6:  a = 21'd10430;
            7:  a = 21'd5215;
            8:  a = 21'd2608;
            9:  a = 21'd1304;
            10: a = 21'd652;
            11: a = 21'd326;
            12: a = 21'd163;
            13: a = 21'd81;
            14: a = 21'd41;
            15: a = 21'd20;
            16: a = 21'd10;
            17: a = 21'd5;
            18: a = 21'd3;
            19: a = 21'd1;
            20: a = 21'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/ascd_cell.sv =====
// One cell of the processing row: a CORDIC vectoring micro-rotation plus a few
// restoring-division steps for the clean path. Depends on ascd_pkg.
module ascd_cell #(
    parameter int CW  = 46,
    parameter int DW  = 40,
    parameter int DPC = 5,
    parameter int IDX = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_v,
    input  logic signed [CW-1:0]            i_x,
    input  logic signed [CW-1:0]            i_y,
    input  logic signed [ascd_pkg::Z_W-1:0] i_z,
    input  logic [DW-1:0]                   i_dq,
    input  logic [ascd_pkg::GAIN_W-1:0]     i_rem,
    input  logic                            i_neg,
    input  logic                            i_nz,
    input  logic [ascd_pkg::GAIN_W-1:0]     i_blend,
    output logic                            o_v,
    output logic signed [CW-1:0]            o_x,
    output logic signed [CW-1:0]            o_y,
    output logic signed [ascd_pkg::Z_W-1:0] o_z,
    output logic [DW-1:0]                   o_dq,
    output logic [ascd_pkg::GAIN_W-1:0]     o_rem,
    output logic                            o_neg,
    output logic                            o_nz
);
    import ascd_pkg::*;

    localparam logic [ANG_W-1:0] ANG = ang_of(IDX);

    logic                   r_v;
    logic signed [CW-1:0]   r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;
    logic [DW-1:0]          r_dq, n_dq;
    logic [GAIN_W-1:0]      r_rem, n_rem;
    logic                   r_neg, r_nz;
    logic signed [CW-1:0]   w_xs, w_ys;

    // micro-rotation; shifts are arithmetic (floor)
    assign w_xs = i_x >>> IDX;
    assign w_ys = i_y >>> IDX;

    always_comb begin
        if (!i_y[CW-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + $signed({1'b0, ANG});
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - $signed({1'b0, ANG});
        end
    end

    // restoring division: dividend shifts out of the top, quotient bits in at the bottom
    always_comb begin
        logic [GAIN_W:0]   t_try;
        logic [GAIN_W-1:0] t_rem;
        logic [DW-1:0]     t_dq;
        t_rem = i_rem;
        t_dq  = i_dq;
        for (int j = 0; j < DPC; j++) begin
            t_try = {t_rem, t_dq[DW-1]};
            if (t_try >= {1'b0, i_blend}) begin
                t_rem = GAIN_W'(t_try - {1'b0, i_blend});
                t_dq  = {t_dq[DW-2:0], 1'b1};
            end else begin
                t_rem = t_try[GAIN_W-1:0];
                t_dq  = {t_dq[DW-2:0], 1'b0};
            end
        end
        n_rem = t_rem;
        n_dq  = t_dq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_dq  <= n_dq;
        r_rem <= n_rem;
        r_neg <= i_neg;
        r_nz  <= i_nz;
    end

    assign o_v   = r_v;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_dq  = r_dq;
    assign o_rem = r_rem;
    assign o_neg = r_neg;
    assign o_nz  = r_nz;

endmodule

// ===== sv/ascd_post.sv =====
// Back end: blend weighting, clean term, sum, volume scaling, rounding and clip.
// Four register stages. Depends on ascd_pkg.
module ascd_post #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DW           = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_v,
    input  logic signed [ascd_pkg::Z_W-1:0]   i_z,
    input  logic [DW-1:0]                     i_dq,
    input  logic                              i_neg,
    input  logic                              i_nz,
    input  logic [ascd_pkg::GAIN_W-1:0]       i_blend,
    input  logic [ascd_pkg::GAIN_W-1:0]       i_volume,
    output logic                              o_done,
    output logic signed [SAMPLE_WIDTH-1:0]    o_sample
);
    import ascd_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int SH     = DIV_W - SW;              // final shift, 35-F
    localparam int DP_W   = Z_W + GAIN_W + 1;
    localparam int DIST_W = DP_W - 15;
    localparam int CL_W   = DIV_W + 1;
    localparam int SUM_W  = CL_W + 1;
    localparam int LO_W   = SUM_W / 2;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int PLO_W  = LO_W + GAIN_W;
    localparam int PHI_W  = HI_W + GAIN_W + 1;
    localparam int PW     = PHI_W + LO_W + 1;
    localparam longint LIM = (longint'(8) << (SW - 1)) / 10;

    localparam logic signed [DP_W-1:0] RND_D     = DP_W'(1) << 14;
    localparam logic signed [PW-1:0]   RND_O     = PW'(1) << (SH - 1);
    localparam logic signed [CL_W-1:0] CLEAN_SAT = CL_W'(64'd1 << (DIV_W - 1));
    localparam logic signed [PW-1:0]   LIM_P     = PW'(LIM);

    logic r_va, r_vb, r_vc, r_vd;

    // stage a: shaped * blend, clean term
    logic signed [DP_W-1:0] r_dp, n_dp;
    logic signed [CL_W-1:0] r_clean, n_clean, w_mag;

    assign n_dp  = i_z * $signed({1'b0, i_blend});
    assign w_mag = $signed({1'b0, i_dq[DIV_W-1:0]});

    always_comb begin
        if (i_blend == '0) begin
            if (!i_nz) begin
                n_clean = '0;
            end else if (i_neg) begin
                n_clean = -CLEAN_SAT;
            end else begin
                n_clean = CLEAN_SAT;
            end
        end else begin
            n_clean = i_neg ? -w_mag : w_mag;
        end
    end

    // stage b: round the distorted term to Q20, add clean
    logic signed [DP_W-1:0]   w_dr;
    logic signed [DIST_W-1:0] w_dist;
    logic signed [SUM_W-1:0]  r_sum, n_sum;

    assign w_dr   = r_dp + RND_D;
    assign w_dist = w_dr[DP_W-1:15];
    assign n_sum  = SUM_W'(w_dist) + SUM_W'(r_clean);

    // stage c: volume product split into two halves
    logic [PLO_W-1:0]         r_plo, n_plo;
    logic signed [PHI_W-1:0]  r_phi, n_phi;

    assign n_plo = r_sum[LO_W-1:0] * i_volume;
    assign n_phi = $signed(r_sum[SUM_W-1:LO_W]) * $signed({1'b0, i_volume});

    // stage d: recombine, round, shift, clip
    logic signed [PW-1:0]     w_tot, w_res;
    logic signed [SW-1:0]     r_out, n_out;

    assign w_tot = (PW'(r_phi) << LO_W) + PW'(r_plo) + RND_O;
    assign w_res = w_tot >>> SH;

    always_comb begin
        if (w_res > LIM_P) begin
            n_out = SW'(LIM_P);
        end else if (w_res < -LIM_P) begin
            n_out = SW'(-LIM_P);
        end else begin
            n_out = w_res[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_v;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dp    <= n_dp;
        r_clean <= n_clean;
        r_sum   <= n_sum;
        r_plo   <= n_plo;
        r_phi   <= n_phi;
        r_out   <= n_out;
    end

    assign o_done   = r_vd;
    assign o_sample = r_out;

endmodule

// ===== sv/atan_soft_clip_distortion.sv =====
// Top level of the arctangent soft-clip distortion: config registers, gain
// front end, the row of CORDIC/divider cells and the back end.
// Depends on ascd_pkg, ascd_cell, ascd_post.
//
// Usage:
//   Input word: drive start high with a sample on i_sample_in; the sample is
//   taken at any rising edge where start is high and busy is low. busy is
//   high only while i_rst_n is low, so a new word can go in every clock.
//   Output word: o_done pulses for one clock with o_sample_out; the
//   receiver has no back-pressure and must take it in that cycle.
//   Pipeline: an accepted word passes two multiplier stages in front
//   (sample*drive, then *range), the cell row (one micro-rotation per
//   cell; stages clamp at 24) and four in the back (blend weighting,
//   sum, split volume product, round and clip) before o_done rises.
//   Throughput: one word per clock, sustained outside reset.
//   Config: i_cfg_we / i_cfg_idx / i_cfg_data write one register per clock
//   (0 drive, 1 range, 2 blend, 3 volume, others ignored). The user must
//   write them only when idle; the block itself does not enforce it.
//   Reset: synchronous; loads the register defaults and drops every word
//   in flight. No clearing pass; the block is ready the clock after reset.
module atan_soft_clip_distortion #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ATAN_STAGES  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_in,
    output logic                                o_done,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    input  logic                                i_cfg_we,
    input  logic [ascd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ascd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ascd_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int NC   = (ATAN_STAGES > TAB_LEN) ? TAB_LEN : ATAN_STAGES;
    localparam int DPC  = (DIV_W + NC - 1) / NC;   // divide steps per cell
    localparam int DW   = NC * DPC;
    localparam int CW   = SW + 30;                 // CORDIC x/y width
    localparam int M1_W = SW + GAIN_W + 1;
    localparam int SH   = DIV_W - SW;

    // x starts at 1.0 in the scale of the product p, 2^(F+15)
    localparam logic signed [CW-1:0] X0 = CW'(1) << (SW + 14);

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0]  r_drive, r_blend, r_volume;
    logic [RANGE_W-1:0] r_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive  <= DRIVE_RST;
            r_range  <= RANGE_RST;
            r_blend  <= BLEND_RST;
            r_volume <= VOLUME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DRIVE:  r_drive  <= i_cfg_data;
                REG_RANGE:  r_range  <= i_cfg_data[RANGE_W-1:0];
                REG_BLEND:  r_blend  <= i_cfg_data;
                REG_VOLUME: r_volume <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input handshake ----------------
    logic w_accept;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // ---------------- front end: p = s * drive * range ----------------
    logic                   r_v1, r_v2;
    logic signed [M1_W-1:0] r_m1, n_m1;
    logic signed [SW-1:0]   r_s1, r_s2;
    logic signed [CW-1:0]   r_p, n_p;

    assign n_m1 = i_sample_in * $signed({1'b0, r_drive});
    assign n_p  = r_m1 * $signed({1'b0, r_range});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1 <= n_m1;
        r_s1 <= i_sample_in;
        r_p  <= n_p;
        r_s2 <= r_s1;
    end

    // clean-path dividend: |s| * 2^(35-F), zero padded to the row's step count
    logic [SW-1:0] w_abs;

    assign w_abs = r_s2[SW-1] ? SW'(-r_s2) : r_s2;

    // ---------------- cell row ----------------
    logic                   c_v   [NC+1];
    logic signed [CW-1:0]   c_x   [NC];
    logic signed [CW-1:0]   c_y   [NC];
    logic signed [Z_W-1:0]  c_z   [NC+1];
    logic [DW-1:0]          c_dq  [NC+1];
    logic [GAIN_W-1:0]      c_rem [NC];
    logic                   c_neg [NC+1];
    logic                   c_nz  [NC+1];

    assign c_v[0]   = r_v2;
    assign c_x[0]   = X0;
    assign c_y[0]   = r_p;
    assign c_z[0]   = '0;
    assign c_dq[0]  = DW'({w_abs, {SH{1'b0}}});
    assign c_rem[0] = '0;
    assign c_neg[0] = r_s2[SW-1];
    assign c_nz[0]  = (r_s2 != '0);

    for (genvar k = 0; k < NC; k++) begin : g_cell
        if (k < NC - 1) begin : g_mid
            ascd_cell #(.CW(CW), .DW(DW), .DPC(DPC), .IDX(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_v     (c_v[k]),
                .i_x     (c_x[k]),
                .i_y     (c_y[k]),
                .i_z     (c_z[k]),
                .i_dq    (c_dq[k]),
                .i_rem   (c_rem[k]),
                .i_neg   (c_neg[k]),
                .i_nz    (c_nz[k]),
                .i_blend (r_blend),
                .o_v     (c_v[k+1]),
                .o_x     (c_x[k+1]),
                .o_y     (c_y[k+1]),
                .o_z     (c_z[k+1]),
                .o_dq    (c_dq[k+1]),
                .o_rem   (c_rem[k+1]),
                .o_neg   (c_neg[k+1]),
                .o_nz    (c_nz[k+1])
            );
        end else begin : g_last
            // last cell: only valid, z, the quotient and the sign flags go on
            ascd_cell #(.CW(CW), .DW(DW), .DPC(DPC), .IDX(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_v     (c_v[k]),
                .i_x     (c_x[k]),
                .i_y     (c_y[k]),
                .i_z     (c_z[k]),
                .i_dq    (c_dq[k]),
                .i_rem   (c_rem[k]),
                .i_neg   (c_neg[k]),
                .i_nz    (c_nz[k]),
                .i_blend (r_blend),
                .o_v     (c_v[k+1]),
                .o_x     (),
                .o_y     (),
                .o_z     (c_z[k+1]),
                .o_dq    (c_dq[k+1]),
                .o_rem   (),
                .o_neg   (c_neg[k+1]),
                .o_nz    (c_nz[k+1])
            );
        end
    end

    // ---------------- back end ----------------
    ascd_post #(.SAMPLE_WIDTH(SW), .DW(DW)) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_v      (c_v[NC]),
        .i_z      (c_z[NC]),
        .i_dq     (c_dq[NC]),
        .i_neg    (c_neg[NC]),
        .i_nz     (c_nz[NC]),
        .i_blend  (r_blend),
        .i_volume (r_volume),
        .o_done   (o_done),
        .o_sample (o_sample_out)
    );

endmodule

// ===== sv/ascd_checker.sv =====
// Port-level checks for the arctangent soft-clip distortion: fixed latency,
// output range and flush on reset. Bound to the top level at the end of the file.
module ascd_checker #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ATAN_STAGES  = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_done,
    input logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);
    localparam int NC    = (ATAN_STAGES > 24) ? 24 : ATAN_STAGES;
    localparam int LAT   = NC + 6;
    localparam int AGE_W = $clog2(LAT + 1);
    localparam longint LIM = (longint'(8) << (SAMPLE_WIDTH - 1)) / 10;
    localparam logic signed [SAMPLE_WIDTH-1:0] LIM_S = SAMPLE_WIDTH'(LIM);

    logic [AGE_W-1:0] r_age, n_age;
    logic             w_warm;

    // clocks since reset, so the latency check never looks back across a flush
    assign n_age  = (r_age == AGE_W'(LAT)) ? r_age : r_age + AGE_W'(1);
    assign w_warm = (r_age >= AGE_W'(LAT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
        end else begin
            r_age <= n_age;
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_warm |-> (o_done == $past(start && !busy, LAT)))
        else $error("result word does not follow its input word at fixed latency");

    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_sample_out <= LIM_S) && (o_sample_out >= -LIM_S))
        else $error("result word outside the clip range");

    a_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result word strobed right after reset");

endmodule

bind atan_soft_clip_distortion ascd_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ATAN_STAGES  (ATAN_STAGES)
) u_ascd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_sample_out (o_sample_out)
);

// ===== dv/tb_atan_soft_clip_distortion.sv =====
// Testbench for atan_soft_clip_distortion: directed table then randomized phases,
// each word checked against a typed-in value or a fixed-point shaper predictor.
// Depends on ascd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_atan_soft_clip_distortion;

    import ascd_pkg::*;

    localparam int SAMPLE_W     = 16;
    localparam int ATAN_STAGES  = 16;
    localparam int FRAC         = SAMPLE_W - 1;
    localparam int ANGLE_N      = 24;
    // CORDIC stages beyond the angle table are skipped
    localparam int STAGES_USED  = (ATAN_STAGES > ANGLE_N) ? ANGLE_N : ATAN_STAGES;
    localparam int PIPE_DEPTH   = STAGES_USED + 5;
    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RAND_PHASES  = 7;
    localparam int WORDS_PER_PH = 150;
    localparam int DIR_N        = 21;
    localparam int MAX_REPORTS  = 10;

    // handy register values
    localparam logic [GAIN_W-1:0]  ONE_Q15    = 16'd32768;
    localparam logic [GAIN_W-1:0]  ONE_Q14    = 16'd16384;
    localparam logic [GAIN_W-1:0]  VOL_MAX    = 16'd49152;
    localparam logic [GAIN_W-1:0]  GAIN_ALL1  = 16'hFFFF;
    localparam logic [RANGE_W-1:0] RANGE_MAX  = 12'd3000;
    localparam logic [RANGE_W-1:0] RANGE_ALL1 = 12'hFFF;
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = REG_VOLUME + 1'b1;
    localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_IDX  = '1;

    // sample extremes and the output clip level (0.8 full scale)
    localparam logic signed [SAMPLE_W-1:0] S_MAX   = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN   = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] OUT_LIM = 16'sd26214;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    logic signed [SAMPLE_W-1:0]    i_sample_in = '0;
    logic                          o_done;
    logic signed [SAMPLE_W-1:0]    o_sample_out;
    logic                          i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data  = '0;

    atan_soft_clip_distortion #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .ATAN_STAGES  (ATAN_STAGES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sample_in  (i_sample_in),
        .o_done       (o_done),
        .o_sample_out (o_sample_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the config registers and the expected-output store
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]  drive_q15;
    logic [RANGE_W-1:0] range_int;
    logic [GAIN_W-1:0]  blend_q15;
    logic [GAIN_W-1:0]  volume_q14;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic signed [SAMPLE_W-1:0] sample_out;
    } t_distort_word;

    t_distort_word pending_outs [$];

    int unsigned words_sent   = 0;
    int unsigned outs_checked = 0;
    int unsigned settings_cnt = 0;
    int unsigned mism_cnt     = 0;
    int unsigned cycle_cnt    = 0;

    // atan(2^-i) * 2/pi in Q20, one entry per micro-rotation
    longint atan_q20 [ANGLE_N] = '{
        524288, 309505, 163534, 83012, 41667, 20854, 10430, 5215,
        2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0, 0, 0
    };

    // Fixed-point waveshaper: drive/range pre-gain, CORDIC atan, blend of
    // shaped and clean paths, halving + volume with rounding, then clip.
    function automatic logic signed [SAMPLE_W-1:0]
            shape_sample(input logic signed [SAMPLE_W-1:0] s);
        longint sv, dg, rg, bg, vg;
        longint x, y, z, xs, ys;
        longint shaped_q20, clean, acc;
        sv = s;
        dg = drive_q15;
        rg = range_int;
        bg = blend_q15;
        vg = volume_q14;
        // vectoring from (1.0, p): z converges to atan(p) * 2/pi in Q20
        x = 64'sd1 <<< (FRAC + 15);
        y = sv * dg * rg;
        z = 0;
        for (int i = 0; i < STAGES_USED; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q20[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q20[i];
            end
        end
        shaped_q20 = (z * bg + (64'sd1 <<< 14)) >>> 15;
        // clean path divides by blend; blend zero saturates it
        if (bg == 0) begin
            clean = (sv > 0) ? (64'sd1 <<< 35) : ((sv < 0) ? -(64'sd1 <<< 35) : 64'sd0);
        end else begin
            clean = (sv * (64'sd1 <<< (35 - FRAC))) / bg;
        end
        acc = ((shaped_q20 + clean) * vg + (64'sd1 <<< (34 - FRAC))) >>> (35 - FRAC);
        if (acc > OUT_LIM)
            acc = OUT_LIM;
        else if (acc < -OUT_LIM)
            acc = -OUT_LIM;
        return acc[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Output checker: every o_done word must match the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_distort_word exp_w;
        if (i_rst_n && o_done) begin
            if (pending_outs.size() == 0) begin
                if (mism_cnt < MAX_REPORTS)
                    $display("[%0t] unexpected output word %0d", $realtime, o_sample_out);
                mism_cnt++;
            end else begin
                exp_w = pending_outs.pop_front();
                outs_checked++;
                if (o_sample_out !== exp_w.sample_out) begin
                    if (mism_cnt < MAX_REPORTS)
                        $display("[%0t] sample_out mismatch: in %0d exp %0d got %0d",
                                 $realtime, exp_w.sample_in, exp_w.sample_out,
                                 o_sample_out);
                    mism_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycle_cnt, pending_outs.size());
            $display("atan_soft_clip_distortion verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // Present one word and hold it until taken. start is left high, so the
    // caller either presents the next word or drops start in this step.
    task automatic send_word(input logic signed [SAMPLE_W-1:0] s,
                             input bit typed, input logic signed [SAMPLE_W-1:0] want);
        t_distort_word w;
        start       <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (busy);
        w.sample_in  = s;
        w.sample_out = typed ? want : shape_sample(s);
        pending_outs = {pending_outs, w};
        words_sent++;
    endtask

    // short sender gap with junk on the data port
    task automatic idle_gap();
        start       <= 1'b0;
        i_sample_in <= SAMPLE_W'($urandom);
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
    endtask

    // config may only change with the pipe empty; every word yields a result
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_outs.size() != 0) @(posedge i_clk);
    endtask

    // Write all four registers, then a junk write to an unused index that
    // must not alias onto any of them.
    task automatic apply_setting(input logic [GAIN_W-1:0] drv, input logic [RANGE_W-1:0] rng,
                                 input logic [GAIN_W-1:0] bln, input logic [GAIN_W-1:0] vol);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] dat [5];
        idx[0] = REG_DRIVE;   dat[0] = drv;
        idx[1] = REG_RANGE;   dat[1] = {4'($urandom), rng};   // top bits are don't-care
        idx[2] = REG_BLEND;   dat[2] = bln;
        idx[3] = REG_VOLUME;  dat[3] = vol;
        idx[4] = CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_UNUSED_IDX));
        dat[4] = CFG_DATA_W'($urandom);
        for (int k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= dat[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        drive_q15  = drv;
        range_int  = rng;
        blend_q15  = bln;
        volume_q14 = vol;
        settings_cnt++;
    endtask

    // gain pick: legal range most often, else zero, top, reset or a raw pattern
    function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] rst_val,
                                                   input logic [GAIN_W-1:0] top);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return top;
            2:       return rst_val;
            5:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] mag;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return '0;
                    3:       return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            1: begin
                // near zero, where the atan is still linear
                mag = SAMPLE_W'($urandom_range(0, 255));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table: register setting, sample, and a typed-in output only
    // where it is obvious (volume zero, blend zero, hard clipping).
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [GAIN_W-1:0]          drv;
        logic [RANGE_W-1:0]         rng;
        logic [GAIN_W-1:0]          bln;
        logic [GAIN_W-1:0]          vol;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] want;
    } t_dir_row;

    t_dir_row dir_rows [DIR_N] = '{
        // reset setting: unity drive, range 1, blend 1.0, volume 1.0
        '{DRIVE_RST, RANGE_RST, BLEND_RST, VOLUME_RST, 16'sd0,     1'b0, 16'sd0},
        '{DRIVE_RST, RANGE_RST, BLEND_RST, VOLUME_RST, S_MAX,      1'b0, 16'sd0},
        '{DRIVE_RST, RANGE_RST, BLEND_RST, VOLUME_RST, S_MIN,      1'b0, 16'sd0},
        '{DRIVE_RST, RANGE_RST, BLEND_RST, VOLUME_RST, 16'sd1,     1'b0, 16'sd0},
        '{DRIVE_RST, RANGE_RST, BLEND_RST, VOLUME_RST, -16'sd1,    1'b0, 16'sd0},
        '{DRIVE_RST, RANGE_RST, BLEND_RST, VOLUME_RST, 16'sd16384, 1'b0, 16'sd0},
        // full volume pushes full scale into the clipper
        '{ONE_Q15, RANGE_RST, ONE_Q15, VOL_MAX, S_MAX,  1'b1, OUT_LIM},
        '{ONE_Q15, RANGE_RST, ONE_Q15, VOL_MAX, S_MIN,  1'b1, -OUT_LIM},
        '{ONE_Q15, RANGE_RST, ONE_Q15, VOL_MAX, 16'sd0, 1'b0, 16'sd0},
        // volume zero mutes everything
        '{ONE_Q15, RANGE_RST, ONE_Q15, 16'd0, S_MAX, 1'b1, 16'sd0},
        '{ONE_Q15, RANGE_RST, ONE_Q15, 16'd0, S_MIN, 1'b1, 16'sd0},
        // blend zero: clean path saturates by sign, zero stays zero
        '{ONE_Q15, RANGE_RST, 16'd0, ONE_Q14, 16'sd0,  1'b1, 16'sd0},
        '{ONE_Q15, RANGE_RST, 16'd0, ONE_Q14, 16'sd5,  1'b1, OUT_LIM},
        '{ONE_Q15, RANGE_RST, 16'd0, ONE_Q14, -16'sd5, 1'b1, -OUT_LIM},
        // blend above one
        '{ONE_Q15, RANGE_RST, GAIN_ALL1, ONE_Q14, S_MAX, 1'b0, 16'sd0},
        '{ONE_Q15, RANGE_RST, GAIN_ALL1, ONE_Q14, S_MIN, 1'b0, 16'sd0},
        // no drive: shaped term is the atan of zero
        '{16'd0, RANGE_RST, ONE_Q15, ONE_Q14, 16'sd20000, 1'b0, 16'sd0},
        // raw all-ones drive and range, deep into saturation
        '{GAIN_ALL1, RANGE_ALL1, ONE_Q15, ONE_Q14, S_MAX,  1'b0, 16'sd0},
        '{GAIN_ALL1, RANGE_ALL1, ONE_Q15, ONE_Q14, S_MIN,  1'b0, 16'sd0},
        '{GAIN_ALL1, RANGE_ALL1, ONE_Q15, ONE_Q14, 16'sd1, 1'b0, 16'sd0},
        // range zero
        '{ONE_Q15, 12'd0, ONE_Q15, ONE_Q14, -16'sd20000, 1'b0, 16'sd0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    typedef bit t_gap_flag;

    initial begin
        t_dir_row  row;
        t_gap_flag gaps_on;

        drive_q15  = DRIVE_RST;
        range_int  = RANGE_RST;
        blend_q15  = BLEND_RST;
        volume_q14 = VOLUME_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; reprogram only when the row's setting changes
        for (int r = 0; r < DIR_N; r++) begin
            row = dir_rows[r];
            if (row.drv != drive_q15 || row.rng != range_int ||
                row.bln != blend_q15 || row.vol != volume_q14) begin
                drain_pipe();
                apply_setting(row.drv, row.rng, row.bln, row.vol);
            end
            send_word(row.sample, row.typed, row.want);
        end

        // random phases, each with a fresh setting; last phase streams
        // back to back to exercise full throughput
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_pipe();
            if (ph == 0)
                apply_setting(ONE_Q15, RANGE_MAX, ONE_Q15, VOL_MAX);
            else
                apply_setting(pick_gain(DRIVE_RST, ONE_Q15),
                              RANGE_W'(pick_gain(GAIN_W'(RANGE_RST), GAIN_W'(RANGE_MAX))),
                              pick_gain(BLEND_RST, ONE_Q15),
                              pick_gain(VOLUME_RST, VOL_MAX));
            gaps_on = (ph != RAND_PHASES - 1);
            for (int k = 0; k < WORDS_PER_PH; k++) begin
                if (gaps_on && $urandom_range(0, 3) == 0)
                    idle_gap();
                send_word(pick_sample(), 1'b0, '0);
            end
        end

        drain_pipe();
        // catch any stray words past the last expected one
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);

        if (pending_outs.size() != 0) begin
            $display("%0d expected words never came out", pending_outs.size());
            mism_cnt += pending_outs.size();
        end

        $display("ran %0d words over %0d register settings, %0d outputs checked",
                 words_sent, settings_cnt, outs_checked);
        $display("%0d mismatches in %0d cycles", mism_cnt, cycle_cnt);
        if (mism_cnt == 0) begin
            $display("atan_soft_clip_distortion verification clean");
        end else begin
            $display("atan_soft_clip_distortion verification failed");
        end
        $finish;
    end

endmodule
